// File: rtl/pva_pkg.sv
// Shared types, constants and helpers for the poly voice allocator.
// No dependencies; every other file in rtl/ imports this package.

package pva_pkg;

    localparam int VOICE_CNT  = 8;
    localparam int IDX_W      = (VOICE_CNT > 1) ? $clog2(VOICE_CNT) : 1;
    localparam int CNT_W      = IDX_W;
    localparam int BUSY_W     = 8;
    localparam int NOTE_W     = 7;
    localparam int TIME_W     = 32;
    localparam int VOICE_W    = 3;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ON      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OFF     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ALL_OFF = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_FREE       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_STEAL_REL  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_STEAL_HELD = 3'd2;
    localparam logic [STATUS_W-1:0] STS_RELEASED   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NO_MATCH   = 3'd4;
    localparam logic [STATUS_W-1:0] STS_IGNORED    = 3'd5;
    localparam logic [STATUS_W-1:0] STS_ALL_OFF    = 3'd6;

    localparam logic [NOTE_W-1:0] SUB_OCTAVE = 7'd12;

    // running search record handed from cell to cell
    typedef struct packed {
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              rel_found;
        logic [IDX_W-1:0]  rel_idx;
        logic [TIME_W-1:0] rel_time;
        logic              held_found;
        logic [IDX_W-1:0]  held_idx;
        logic [TIME_W-1:0] held_time;
        logic              match_found;
        logic [IDX_W-1:0]  match_idx;
    } cand_t;

    // state update broadcast to all cells
    typedef struct packed {
        logic              take;
        logic              release_one;
        logic              all_off;
        logic [IDX_W-1:0]  idx;
        logic [NOTE_W-1:0] note;
        logic [TIME_W-1:0] stamp;
    } commit_t;

    // voice index folded into the 3-bit output field
    function automatic logic [VOICE_W-1:0] to_voice(input logic [IDX_W-1:0] idx);
        logic [IDX_W+VOICE_W-1:0] wide;
        wide = {{VOICE_W{1'b0}}, idx};
        return wide[VOICE_W-1:0];
    endfunction

endpackage

// File: rtl/pva_cell.sv
// One voice cell: holds held flag, note and start time, and folds itself
// into the search record passed down the chain. Depends on pva_pkg.

module pva_cell
    import pva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [NOTE_W-1:0] req_note,
    input  logic              env_busy,
    input  cand_t             cand_in,
    output cand_t             cand_out,
    input  commit_t           commit
);

    logic              held_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [TIME_W-1:0] time_reg;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic              hit;

    assign hit = (commit.idx == cell_idx);

    always_comb
    begin
        cand_next = cand_in;
        if (!cand_in.free_found && !held_reg && !env_busy)
        begin
            cand_next.free_found = 1'b1;
            cand_next.free_idx   = cell_idx;
        end
        if (held_reg)
        begin
            // strict compare: an earlier cell wins a tie
            if (!cand_in.held_found || time_reg < cand_in.held_time)
            begin
                cand_next.held_found = 1'b1;
                cand_next.held_idx   = cell_idx;
                cand_next.held_time  = time_reg;
            end
            if (!cand_in.match_found && note_reg == req_note)
            begin
                cand_next.match_found = 1'b1;
                cand_next.match_idx   = cell_idx;
            end
        end
        else if (env_busy)
        begin
            if (!cand_in.rel_found || time_reg < cand_in.rel_time)
            begin
                cand_next.rel_found = 1'b1;
                cand_next.rel_idx   = cell_idx;
                cand_next.rel_time  = time_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            note_reg <= '0;
            time_reg <= '0;
        end
        else if (commit.all_off)
        begin
            held_reg <= 1'b0;
            note_reg <= '0;
        end
        else if (commit.take && hit)
        begin
            held_reg <= 1'b1;
            note_reg <= commit.note;
            time_reg <= commit.stamp;
        end
        else if (commit.release_one && hit)
        begin
            held_reg <= 1'b0;
            note_reg <= '0;
        end
    end

endmodule

// File: rtl/poly_voice_allocator.sv
// Top level of the poly voice allocator: request stream in, one result beat
// out per request. Depends on pva_pkg and pva_cell.
//
// Usage: s_* carries requests: s_tuser = req_type (0 note on, 1 note off,
//   2 all off), s_tdata = note, timestamp, envelope_busy. m_* returns one
//   result beat per request: m_tdata = voice, sub_plays; m_tuser = status.
//   cfg_we/cfg_wdata write instrument_loaded; write only while idle.
// Operation:
//   A request beat is taken only when the block is idle. It then walks a
//   row of VOICE_CNT voice cells, one cell per cycle, each folding its
//   voice into a registered search record (first free, oldest releasing,
//   oldest held, first note match). A decide step then updates the
//   chosen cell and loads the output register. The block returns to idle
//   and takes the next request only after that decide step, so it never
//   works on two requests at once.
// Reset: all voices go not-held with note and start time 0; no instrument.
// Stall: a waiting result holds in the output register; the decide step
//   waits until the register is free, and no new request is taken meanwhile.

module poly_voice_allocator
    import pva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // instrument_loaded
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,        // [6:0] note, [38:7] timestamp,
                                        // [46:39] envelope_busy, [47] zero
    input  logic [1:0]  s_tuser,        // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // [2:0] voice, [3] sub_plays, [7:4] zero
    output logic [2:0]  m_tuser         // [2:0] status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              loaded_reg;

    // request held for the whole walk
    logic [REQ_W-1:0]  req_type_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic [BUSY_W-1:0] busy_reg;

    logic                out_valid_reg;
    logic [VOICE_W-1:0]  out_voice_reg, out_voice_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_sub_reg, out_sub_next;

    cand_t   chain [VOICE_CNT+1];
    cand_t   fin;
    commit_t commit;
    logic    fire;
    logic    in_beat;

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign fire     = (state_reg == S_DECIDE) && (!out_valid_reg || m_tready);

    assign chain[0] = '0;
    assign fin      = chain[VOICE_CNT];

    genvar gi;
    generate
        for (gi = 0; gi < VOICE_CNT; gi++)
        begin : g_cell
            logic env_bit;
            if (gi < BUSY_W)
            begin : g_busy
                assign env_bit = busy_reg[gi];
            end
            else
            begin : g_idle
                // voices beyond the mask read as idle
                assign env_bit = 1'b0;
            end
            pva_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(gi)),
                .req_note (note_reg),
                .env_busy (env_bit),
                .cand_in  (chain[gi]),
                .cand_out (chain[gi+1]),
                .commit   (commit)
            );
        end
    endgenerate

    // decision on the finished search record
    always_comb
    begin
        commit          = '0;
        commit.note     = note_reg;
        commit.stamp    = stamp_reg;
        out_voice_next  = '0;
        out_status_next = STS_IGNORED;
        out_sub_next    = 1'b0;
        case (req_type_reg)
            REQ_ON:
            begin
                if (loaded_reg)
                begin
                    commit.take = fire;
                    if (fin.free_found)
                    begin
                        commit.idx      = fin.free_idx;
                        out_status_next = STS_FREE;
                    end
                    else if (fin.rel_found)
                    begin
                        commit.idx      = fin.rel_idx;
                        out_status_next = STS_STEAL_REL;
                    end
                    else if (fin.held_found)
                    begin
                        commit.idx      = fin.held_idx;
                        out_status_next = STS_STEAL_HELD;
                    end
                    else
                    begin
                        commit.idx      = '0;
                        out_status_next = STS_STEAL_HELD;
                    end
                    out_voice_next = to_voice(commit.idx);
                    out_sub_next   = (note_reg >= SUB_OCTAVE);
                end
            end
            REQ_OFF:
            begin
                if (fin.match_found)
                begin
                    commit.release_one = fire;
                    commit.idx         = fin.match_idx;
                    out_voice_next     = to_voice(fin.match_idx);
                    out_status_next    = STS_RELEASED;
                end
                else
                begin
                    out_status_next = STS_NO_MATCH;
                end
            end
            REQ_ALL_OFF:
            begin
                commit.all_off  = fire;
                out_status_next = STS_ALL_OFF;
            end
            default:
            begin
                out_status_next = STS_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VOICE_CNT - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                loaded_reg <= cfg_wdata;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            req_type_reg <= s_tuser;
            note_reg     <= s_tdata[6:0];
            stamp_reg    <= s_tdata[38:7];
            busy_reg     <= s_tdata[46:39];
        end
        if (fire)
        begin
            out_voice_reg  <= out_voice_next;
            out_status_reg <= out_status_next;
            out_sub_reg    <= out_sub_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_sub_reg, out_voice_reg};
    assign m_tuser  = out_status_reg;

endmodule
